FILE: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/nps_pkg.sv
package nps_pkg;

    // status of the shared remainder unit
    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } t_mod_stat;

    localparam int unsigned C_TWO      = 2;
    localparam int unsigned C_THREE    = 3;
    localparam int unsigned C_FIVE     = 5;
    localparam int unsigned C_SIX      = 6;
    localparam int unsigned C_SQ_FIRST = 25;
    localparam int unsigned C_SQ_STEP  = 36;

endpackage

FILE: hw/rtl/nps_mod.sv
module nps_mod #(
    parameter int CW = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [CW-1:0]       i_dividend,
    input  logic [CW-1:0]       i_divisor,
    output nps_pkg::t_mod_stat  o_stat
);
    import nps_pkg::*;

    localparam int CNTW = $clog2(CW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [CW-1:0]   r_rem;
    logic [CW-1:0]   r_quo;
    logic [CW-1:0]   r_div;

    logic [CW:0]     w_trial;
    logic [CW:0]     w_diff;
    logic            w_ge;

    // restoring remainder, one dividend bit per cycle
    assign w_trial = {r_rem, r_quo[CW-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(CW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[CW-1:0] : w_trial[CW-1:0];
            r_quo <= {r_quo[CW-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.zero = (r_rem == '0);

endmodule

FILE: hw/rtl/next_prime_search.sv
// next_prime_search
// request channel: i_valid / o_stall with i_number; a request is taken at a
// clock edge where i_valid is high and o_stall is low.
// result channel: o_valid / i_stall with o_input_is_prime and o_next_prime;
// a result is taken at an edge where o_valid is high and i_stall is low.
// one request is worked on at a time; o_stall stays high until the search
// for that request has finished, and drops in the cycle after the result loads.
// every trial divisor runs through the shared bit-serial remainder unit,
// and each divisor pair adds a square check. a candidate is tried with 3,
// then with pairs d and d+2 from d=5 in steps of 6 while d*d does not
// exceed it. inputs 0 and 1 skip trial division; otherwise search time is
// set by the number of divisors tried over all candidates to the next prime.
// the finished result sits in an output register; a new request is taken
// while it waits, and a later result waits in the sequencer until the
// output register is free. a stalled result holds its value.
// synchronous active-low reset returns to idle and drops o_valid.
`include "assert_macros.svh"

module next_prime_search #(
    parameter int NUM_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [NUM_WIDTH-1:0] i_number,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_input_is_prime,
    output logic [NUM_WIDTH:0]   o_next_prime
);
    import nps_pkg::*;

    localparam int CW = NUM_WIDTH + 1;
    localparam int SW = 2 * CW;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TEST   = 3'd1;
    localparam logic [2:0] S_WAIT3  = 3'd2;
    localparam logic [2:0] S_CHKSQ  = 3'd3;
    localparam logic [2:0] S_WAITD  = 3'd4;
    localparam logic [2:0] S_WAITD2 = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cand, n_cand;
    logic [CW-1:0] r_d, n_d;
    logic [SW-1:0] r_dsq, n_dsq;
    logic          r_first, n_first;
    logic          r_small, n_small;
    logic          r_isp, n_isp;
    logic          r_ovalid, n_ovalid;
    logic          r_oisp;
    logic [CW-1:0] r_onext;

    logic          w_fin;
    logic          w_fin_prime;
    logic          w_load;
    logic          w_mod_start;
    logic [CW-1:0] w_mod_div;
    t_mod_stat     w_mod_stat;
    logic          w_mod_wait;

    nps_mod #(
        .CW (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_cand),
        .i_divisor  (w_mod_div),
        .o_stat     (w_mod_stat)
    );

    always_comb begin
        n_state     = r_state;
        n_cand      = r_cand;
        n_d         = r_d;
        n_dsq       = r_dsq;
        n_first     = r_first;
        n_small     = r_small;
        n_isp       = r_isp;
        w_fin       = 1'b0;
        w_fin_prime = 1'b0;
        w_load      = 1'b0;
        w_mod_start = 1'b0;
        w_mod_div   = r_d;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cand  = {1'b0, i_number};
                    n_first = 1'b1;
                    n_small = (i_number <= NUM_WIDTH'(1));
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                priority if (r_cand <= CW'(1)) begin
                    w_fin = 1'b1;
                end else if (r_cand <= CW'(C_THREE)) begin
                    w_fin       = 1'b1;
                    w_fin_prime = 1'b1;
                end else if (!r_cand[0]) begin
                    w_fin = 1'b1;
                end else begin
                    w_mod_start = 1'b1;
                    w_mod_div   = CW'(C_THREE);
                    n_state     = S_WAIT3;
                end
            end
            S_WAIT3: begin
                if (w_mod_stat.done) begin
                    if (w_mod_stat.zero) begin
                        w_fin = 1'b1;
                    end else begin
                        n_d     = CW'(C_FIVE);
                        n_dsq   = SW'(C_SQ_FIRST);
                        n_state = S_CHKSQ;
                    end
                end
            end
            S_CHKSQ: begin
                if (r_dsq > SW'(r_cand)) begin
                    w_fin       = 1'b1;
                    w_fin_prime = 1'b1;
                end else begin
                    w_mod_start = 1'b1;
                    n_state     = S_WAITD;
                end
            end
            S_WAITD: begin
                if (w_mod_stat.done) begin
                    if (w_mod_stat.zero) begin
                        w_fin = 1'b1;
                    end else begin
                        w_mod_start = 1'b1;
                        w_mod_div   = r_d + CW'(C_TWO);
                        n_state     = S_WAITD2;
                    end
                end
            end
            S_WAITD2: begin
                if (w_mod_stat.done) begin
                    if (w_mod_stat.zero) begin
                        w_fin = 1'b1;
                    end else begin
                        // (d+6)^2 = d^2 + 12d + 36
                        n_d     = r_d + CW'(C_SIX);
                        n_dsq   = r_dsq + (SW'(r_d) << 3) + (SW'(r_d) << 2)
                                + SW'(C_SQ_STEP);
                        n_state = S_CHKSQ;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // verdict on the current candidate
        if (w_fin) begin
            if (r_first) begin
                n_isp   = w_fin_prime;
                n_first = 1'b0;
                if (r_small) begin
                    n_cand  = CW'(C_TWO);
                    n_state = S_DONE;
                end else begin
                    n_cand  = r_cand + 1'b1;
                    n_state = S_TEST;
                end
            end else if (w_fin_prime) begin
                n_state = S_DONE;
            end else begin
                n_cand  = r_cand + 1'b1;
                n_state = S_TEST;
            end
        end

        n_ovalid = r_ovalid;
        if (w_load) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_first  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_first  <= n_first;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand  <= n_cand;
        r_d     <= n_d;
        r_dsq   <= n_dsq;
        r_small <= n_small;
        r_isp   <= n_isp;
        if (w_load) begin
            r_oisp  <= r_isp;
            r_onext <= r_cand;
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_input_is_prime = r_oisp;
    assign o_next_prime     = r_onext;

    assign w_mod_wait = (r_state == S_WAIT3) || (r_state == S_WAITD)
                     || (r_state == S_WAITD2);

    `NPS_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "not stalled")
    `NPS_ASSERT_IMP(a_min_two, i_clk, i_rst_n, o_valid, o_next_prime >= CW'(C_TWO), "below two")
    `NPS_ASSERT_IMP(a_done_in_wait, i_clk, i_rst_n, w_mod_stat.done, w_mod_wait, "stray done")
    `NPS_ASSERT_IMP(a_no_start_busy, i_clk, i_rst_n, w_mod_start, !w_mod_stat.busy, "busy restart")

endmodule
